// File: hw/rtl/ico_container_parser_core_macros.svh
// Assertion macros for the icon container parser core
`ifndef ICO_CONTAINER_PARSER_CORE_MACROS_SVH
`define ICO_CONTAINER_PARSER_CORE_MACROS_SVH
// assert that a condition implies a consequence in the same cycle
`define ICP_ASSERT_IMPL(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
// assert that a condition implies a consequence in the next cycle
`define ICP_ASSERT_NEXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// File: hw/rtl/icp_pkg.sv
// Shared types and constants for the icon container parser
package icp_pkg;
    localparam int MAX_ENTRIES_DEF = 256;
    localparam int QDEPTH = 4;
    localparam int RES_Q_DEPTH = 16;

    localparam logic [2:0] K_HDR   = 3'd0;
    localparam logic [2:0] K_INFO  = 3'd1;
    localparam logic [2:0] K_SEEK  = 3'd2;
    localparam logic [2:0] K_FMT   = 3'd3;
    localparam logic [2:0] K_DATA  = 3'd4;
    localparam logic [2:0] K_DONE  = 3'd5;
    localparam logic [2:0] K_ERR   = 3'd6;

    localparam logic [1:0] F_PNG = 2'd0;
    localparam logic [1:0] F_BMP = 2'd1;
    localparam logic [1:0] F_UNK = 2'd2;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  data_byte;
        logic [15:0] entry_index;
    } item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [8:0]  image_width;
        logic [8:0]  image_height;
        logic [15:0] bits_per_pixel;
        logic        bgr_order;
        logic [31:0] data_size;
        logic [31:0] data_offset;
        logic [15:0] entry_total;
        logic [1:0]  image_format;
        logic [31:0] bmp_header_size;
        logic [7:0]  out_byte;
        logic        last;
    } result_t;
endpackage

// File: hw/rtl/icp_front.sv
// Input front end: a short queue of accepted items
module icp_front #(
    parameter int DEPTH = icp_pkg::QDEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  icp_pkg::item_t in_item,
    output logic           q_valid,
    input  logic           q_take,
    output icp_pkg::item_t q_item
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    icp_pkg::item_t mem [DEPTH];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0]   cnt_reg;
    logic push, pop;

    assign in_stall = (cnt_reg == (AW+1)'(DEPTH));
    assign push = in_valid && !in_stall;
    assign q_valid = (cnt_reg != '0);
    assign pop = q_take && q_valid;
    assign q_item = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == AW'(DEPTH-1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == AW'(DEPTH-1)) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule

// File: hw/rtl/icp_back.sv
// Parser engine: runs the phase machine and emits result beats one a cycle, taking no item while busy or full
module icp_back #(
    parameter int MAX_ENTRIES = icp_pkg::MAX_ENTRIES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    output logic             q_take,
    input  icp_pkg::item_t   q_item,
    output logic             r_valid,
    input  logic             r_full,
    output icp_pkg::result_t r_res
);
    localparam int TD = MAX_ENTRIES;
    localparam int TW = (TD > 1) ? $clog2(TD) : 1;

    typedef enum logic [4:0] {
        PH_HDR  = 5'b00001,
        PH_ENTS = 5'b00010,
        PH_WAIT = 5'b00100,
        PH_FMT  = 5'b01000,
        PH_DATA = 5'b10000
    } phase_t;

    // sequencer for multi-beat bursts
    typedef enum logic [5:0] {
        SQ_IDLE = 6'b000001,
        SQ_SEL  = 6'b000010,
        SQ_SEL2 = 6'b000100,
        SQ_FMT  = 6'b001000,
        SQ_ENT  = 6'b010000,
        SQ_PASS = 6'b100000
    } seq_t;

    phase_t phase_reg;
    seq_t   seq_reg;
    logic [3:0]  bc_reg;
    logic [7:0]  gb [16];
    logic [15:0] total_reg, seen_reg;
    logic [33:0] geo [TD];
    logic [63:0] loc [TD];
    logic [33:0] geo_rd;
    logic [63:0] loc_rd;
    logic [8:0]  selw_reg;
    logic [31:0] left_reg;
    logic [3:0]  pass_reg;
    logic        sel_ok_reg;
    logic [1:0]  fmt_reg;
    logic [31:0] bmp_reg;
    logic [TW-1:0] rd_addr;
    logic        ent_hdr_reg;
    logic        done_reg;
    logic        ent_wr;
    logic [33:0] geo_wr;
    logic [63:0] loc_wr;

    icp_pkg::result_t res;
    logic        emit;

    wire [7:0] b = q_item.data_byte;
    wire [15:0] idx = q_item.entry_index;
    wire [8:0] ew = (gb[0] == 8'd0) ? 9'd256 : {1'b0, gb[0]};
    wire [8:0] eh = (gb[1] == 8'd0) ? 9'd256 : {1'b0, gb[1]};
    wire [15:0] ebpp = {gb[7], gb[6]};
    wire [15:0] rbpp = geo_rd[33:18];

    assign ent_wr = q_take && !q_item.cmd && phase_reg == PH_ENTS && bc_reg == 4'd15;
    assign geo_wr = {ebpp, eh, ew};
    assign loc_wr = {b, gb[14], gb[13], gb[12], gb[11], gb[10], gb[9], gb[8]};

    // the select pipeline uses a registered table read, ready in the cycle after the command; hold the read
    // while a burst runs and forward a completing entry
    always_ff @(posedge clk)
    begin
        if (ent_wr)
        begin
            geo_rd <= geo_wr;
            loc_rd <= loc_wr;
        end
        else if (seq_reg == SQ_IDLE)
        begin
            geo_rd <= geo[rd_addr];
            loc_rd <= loc[rd_addr];
        end
    end

    always_comb
    begin
        rd_addr = idx[TW-1:0];
        if (seq_reg == SQ_IDLE && !q_item.cmd && phase_reg == PH_ENTS)
        begin
            rd_addr = seen_reg[TW-1:0];
        end
    end

    function automatic icp_pkg::result_t blank(input logic [2:0] k);
        icp_pkg::result_t r;
        r = '0;
        r.kind = k;
        return r;
    endfunction

    // entry result from registered table read
    function automatic icp_pkg::result_t ent_res(input logic [2:0] k, input logic [33:0] g,
                                                input logic [63:0] l);
        icp_pkg::result_t r;
        r = blank(k);
        r.image_width = g[8:0];
        r.image_height = g[17:9];
        r.bits_per_pixel = g[33:18];
        r.bgr_order = (g[33:18] == 16'd24) || (g[33:18] == 16'd32);
        r.data_size = l[31:0];
        r.data_offset = l[63:32];
        return r;
    endfunction

    wire busy = (seq_reg != SQ_IDLE) || done_reg;
    assign q_take = q_valid && !busy && !r_full;

    always_comb
    begin
        res = blank(icp_pkg::K_ERR);
        emit = 1'b0;
        case (seq_reg)
            SQ_SEL:
            begin
                emit = 1'b1;
                if (!sel_ok_reg)
                begin
                    res = blank(icp_pkg::K_ERR);
                    res.last = 1'b1;
                end
                else
                begin
                    res = ent_res(icp_pkg::K_INFO, geo_rd, loc_rd);
                end
            end
            SQ_SEL2:
            begin
                emit = 1'b1;
                res = (left_reg <= 32'd8) ? blank(icp_pkg::K_ERR)
                                          : ent_res(icp_pkg::K_SEEK, geo_rd, loc_rd);
                res.last = 1'b1;
            end
            SQ_ENT:
            begin
                emit = 1'b1;
                res = ent_res(icp_pkg::K_INFO, geo_rd, loc_rd);
                res.last = !ent_hdr_reg;
            end
            SQ_FMT:
            begin
                emit = 1'b1;
                res = blank(icp_pkg::K_FMT);
                res.image_format = fmt_reg;
                res.bmp_header_size = bmp_reg;
            end
            SQ_PASS:
            begin
                emit = 1'b1;
                if (pass_reg[3])
                begin
                    res = blank(icp_pkg::K_HDR);
                    res.entry_total = total_reg;
                    res.last = 1'b1;
                end
                else
                begin
                    res = blank(icp_pkg::K_DATA);
                    res.out_byte = gb[{1'b0, pass_reg[2:0]}];
                    res.last = (pass_reg[2:0] == 3'd7);
                end
            end
            default:
            begin
                if (q_take && !q_item.cmd)
                begin
                    case (phase_reg)
                        PH_HDR:
                        begin
                            if (bc_reg == 4'd5)
                            begin
                                if ({gb[3], gb[2]} != 16'd1 || {b, gb[4]} > 16'(MAX_ENTRIES))
                                begin
                                    emit = 1'b1;
                                    res = blank(icp_pkg::K_ERR);
                                    res.last = 1'b1;
                                end
                                else if ({b, gb[4]} == 16'd0)
                                begin
                                    emit = 1'b1;
                                    res = blank(icp_pkg::K_HDR);
                                    res.last = 1'b1;
                                end
                            end
                        end
                        PH_ENTS, PH_FMT: ;
                        PH_DATA:
                        begin
                            emit = 1'b1;
                            res = blank(icp_pkg::K_DATA);
                            res.out_byte = b;
                            res.last = (left_reg != 32'd1);
                            res.last = 1'b0;
                            if (left_reg == 32'd1)
                            begin
                                res.last = 1'b0;
                            end
                            else
                            begin
                                res.last = 1'b1;
                            end
                        end
                        default:
                        begin
                            emit = 1'b1;
                            res = blank(icp_pkg::K_ERR);
                            res.last = 1'b1;
                        end
                    endcase
                end
            end
        endcase
    end

    // done beat after the final data byte is handled by a one-cycle tail flag

    always_comb
    begin
        r_valid = emit || done_reg;
        r_res = done_reg ? blank(icp_pkg::K_DONE) : res;
        if (done_reg)
        begin
            r_res.last = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_take && !q_item.cmd)
        begin
            case (phase_reg)
                PH_HDR:  gb[bc_reg] <= b;
                PH_ENTS: gb[bc_reg] <= b;
                PH_FMT:  gb[{1'b0, bc_reg[2:0]}] <= b;
                default: ;
            endcase
        end
        if (ent_wr)
        begin
            geo[seen_reg[TW-1:0]] <= geo_wr;
            loc[seen_reg[TW-1:0]] <= loc_wr;
        end
        if (q_take && !q_item.cmd && phase_reg == PH_FMT && bc_reg == 4'd7)
        begin
            bmp_reg <= 32'd0;
            if ({gb[0], gb[1], gb[2], gb[3], gb[4], gb[5], gb[6], b} ==
                64'h89504E470D0A1A0A)
            begin
                fmt_reg <= icp_pkg::F_PNG;
            end
            else if ({b, gb[6], gb[5], gb[4]} == {23'd0, selw_reg})
            begin
                fmt_reg <= icp_pkg::F_BMP;
                bmp_reg <= {gb[3], gb[2], gb[1], gb[0]};
            end
            else
            begin
                fmt_reg <= icp_pkg::F_UNK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR;
            seq_reg <= SQ_IDLE;
            bc_reg <= '0;
            total_reg <= '0;
            seen_reg <= '0;
            selw_reg <= '0;
            left_reg <= '0;
            pass_reg <= '0;
            sel_ok_reg <= 1'b0;
            ent_hdr_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (seq_reg)
                SQ_SEL:
                begin
                    if (!sel_ok_reg)
                    begin
                        phase_reg <= PH_WAIT;
                        seq_reg <= SQ_IDLE;
                    end
                    else
                    begin
                        selw_reg <= geo_rd[8:0];
                        left_reg <= loc_rd[31:0];
                        seq_reg <= SQ_SEL2;
                    end
                end
                SQ_SEL2:
                begin
                    seq_reg <= SQ_IDLE;
                    if (left_reg <= 32'd8)
                    begin
                        phase_reg <= PH_WAIT;
                    end
                    else
                    begin
                        phase_reg <= PH_FMT;
                        bc_reg <= '0;
                    end
                end
                SQ_ENT:
                begin
                    seq_reg <= ent_hdr_reg ? SQ_PASS : SQ_IDLE;
                    pass_reg <= 4'd8;
                end
                SQ_FMT:
                begin
                    seq_reg <= SQ_PASS;
                    pass_reg <= 4'd0;
                end
                SQ_PASS:
                begin
                    if (pass_reg[3] || pass_reg[2:0] == 3'd7)
                    begin
                        seq_reg <= SQ_IDLE;
                    end
                    pass_reg <= pass_reg + 4'd1;
                end
                default:
                begin
                    if (q_take && q_item.cmd)
                    begin
                        sel_ok_reg <= (seen_reg == total_reg) && (idx < seen_reg) &&
                                      (phase_reg != PH_HDR) && (phase_reg != PH_ENTS);
                        seq_reg <= SQ_SEL;
                    end
                    else if (q_take)
                    begin
                        case (phase_reg)
                            PH_HDR:
                            begin
                                if (bc_reg != 4'd5)
                                begin
                                    bc_reg <= bc_reg + 4'd1;
                                end
                                else
                                begin
                                    bc_reg <= '0;
                                    if ({gb[3], gb[2]} != 16'd1 ||
                                        {b, gb[4]} > 16'(MAX_ENTRIES))
                                    begin
                                        phase_reg <= PH_WAIT;
                                    end
                                    else
                                    begin
                                        total_reg <= {b, gb[4]};
                                        seen_reg <= '0;
                                        phase_reg <= ({b, gb[4]} == 16'd0) ? PH_WAIT
                                                                          : PH_ENTS;
                                    end
                                end
                            end
                            PH_ENTS:
                            begin
                                if (bc_reg != 4'd15)
                                begin
                                    bc_reg <= bc_reg + 4'd1;
                                end
                                else
                                begin
                                    bc_reg <= '0;
                                    seen_reg <= seen_reg + 16'd1;
                                    ent_hdr_reg <= (seen_reg + 16'd1 >= total_reg);
                                    if (seen_reg + 16'd1 >= total_reg)
                                    begin
                                        phase_reg <= PH_WAIT;
                                    end
                                    seq_reg <= SQ_ENT;
                                end
                            end
                            PH_FMT:
                            begin
                                if (bc_reg[2:0] != 3'd7)
                                begin
                                    bc_reg <= bc_reg + 4'd1;
                                end
                                else
                                begin
                                    left_reg <= left_reg - 32'd8;
                                    phase_reg <= PH_DATA;
                                    bc_reg <= '0;
                                    seq_reg <= SQ_FMT;
                                end
                            end
                            PH_DATA:
                            begin
                                left_reg <= left_reg - 32'd1;
                                if (left_reg == 32'd1)
                                begin
                                    done_reg <= 1'b1;
                                    phase_reg <= PH_WAIT;
                                end
                            end
                            default:
                            begin
                                phase_reg <= PH_WAIT;
                            end
                        endcase
                    end
                end
            endcase
        end
    end
endmodule

// File: hw/rtl/icp_outq.sv
// Output result queue that absorbs bursts and drives the result channel
module icp_outq #(
    parameter int DEPTH = icp_pkg::RES_Q_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             w_valid,
    input  icp_pkg::result_t w_res,
    output logic             w_full,
    output logic             out_valid,
    input  logic             out_stall,
    output icp_pkg::result_t out_res
);
    localparam int AW = $clog2(DEPTH);
    icp_pkg::result_t mem [DEPTH];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0]   cnt_reg;
    logic pop;

    // hold headroom for a full burst plus the beat in flight
    assign w_full = (cnt_reg > (AW+1)'(DEPTH - 11));
    assign out_valid = (cnt_reg != '0);
    assign pop = out_valid && !out_stall;
    assign out_res = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (w_valid)
        begin
            mem[wr_reg] <= w_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (w_valid)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(w_valid) - (AW+1)'(pop);
        end
    end
endmodule

// File: hw/rtl/ico_container_parser_core.sv
// Top level of the icon container parser core
// An accepted byte beat is registered in the input queue and again in the output queue.
// One byte beat is taken a cycle unless a result burst runs or the result queue is full;
// bursts follow a select, an entry end, the eighth image byte and the final image byte.
// Reset: rst_n clears all control state at once; the directory tables are not cleared.
`include "ico_container_parser_core_macros.svh"
module ico_container_parser_core #(
    parameter int MAX_ENTRIES = icp_pkg::MAX_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [7:0]  data_byte,
    input  logic [15:0] entry_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [8:0]  image_width,
    output logic [8:0]  image_height,
    output logic [15:0] bits_per_pixel,
    output logic        bgr_order,
    output logic [31:0] data_size,
    output logic [31:0] data_offset,
    output logic [15:0] entry_total,
    output logic [1:0]  image_format,
    output logic [31:0] bmp_header_size,
    output logic [7:0]  out_byte,
    output logic        last
);
    icp_pkg::item_t   in_item, q_item;
    icp_pkg::result_t r_res, o_res;
    logic q_valid, q_take, r_valid, r_full;

    assign in_item = '{cmd: cmd, data_byte: data_byte, entry_index: entry_index};

    icp_front #(.DEPTH(icp_pkg::QDEPTH)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_item(in_item), .q_valid(q_valid), .q_take(q_take), .q_item(q_item)
    );

    icp_back #(.MAX_ENTRIES(MAX_ENTRIES)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_take(q_take), .q_item(q_item),
        .r_valid(r_valid), .r_full(r_full), .r_res(r_res)
    );

    icp_outq #(.DEPTH(icp_pkg::RES_Q_DEPTH)) u_outq (
        .clk(clk), .rst_n(rst_n), .w_valid(r_valid), .w_res(r_res), .w_full(r_full),
        .out_valid(out_valid), .out_stall(out_stall), .out_res(o_res)
    );

    assign kind = o_res.kind;
    assign image_width = o_res.image_width;
    assign image_height = o_res.image_height;
    assign bits_per_pixel = o_res.bits_per_pixel;
    assign bgr_order = o_res.bgr_order;
    assign data_size = o_res.data_size;
    assign data_offset = o_res.data_offset;
    assign entry_total = o_res.entry_total;
    assign image_format = o_res.image_format;
    assign bmp_header_size = o_res.bmp_header_size;
    assign out_byte = o_res.out_byte;
    assign last = o_res.last;

    `ICP_ASSERT_IMPL(a_take_valid, clk, rst_n, q_take, q_valid)
    `ICP_ASSERT_IMPL(a_no_take_full, clk, rst_n, r_full, !q_take)
    `ICP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
endmodule
